// ===== hdl/dmx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared types, codes and helper functions of the decimal digit mark extractor.
// ----------------------------------------------------------------------------
package dmx_pkg;

  // Event codes on the result channel
  localparam logic [1:0] EV_BYTE      = 2'd0;
  localparam logic [1:0] EV_DISCARD   = 2'd1;
  localparam logic [1:0] EV_FOUND     = 2'd2;
  localparam logic [1:0] EV_NOT_FOUND = 2'd3;

  // Configuration register indexes
  localparam logic REG_MARK_KIND    = 1'b0;
  localparam logic REG_PIXEL_FORMAT = 1'b1;

  // Mark kinds
  localparam logic MARK_TEXT  = 1'b0;
  localparam logic MARK_IMAGE = 1'b1;

  // Source of one lane's channel byte when the pixel is RGB565
  localparam logic [1:0] FLD_ALPHA = 2'd0;
  localparam logic [1:0] FLD_FIVE  = 2'd1;
  localparam logic [1:0] FLD_SIX   = 2'd2;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned MaxEvents = 3;
  localparam int unsigned MarkLen   = 4;

  // c*255/31 and c*255/63 as a multiply by a scaled reciprocal, then >> 20
  localparam int unsigned ExpandShift = 20;
  localparam logic [28:0] Expand5Mul  = 29'd8625630;  // 255 * ceil(2^20/31)
  localparam logic [28:0] Expand6Mul  = 29'd4244475;  // 255 * ceil(2^20/63)
  localparam logic [7:0]  AlphaOpaque = 8'hff;

  // x/10 for x < 256 as (x*205) >> 11
  localparam int unsigned Div10Shift = 11;
  localparam logic [15:0] Div10Mul   = 16'd205;

  // First digit of each mark; marks alternate between base and base+1
  localparam logic [3:0] StartBaseText  = 4'd2;
  localparam logic [3:0] StartBaseImage = 4'd1;
  localparam logic [3:0] EndBaseText    = 4'd4;
  localparam logic [3:0] EndBaseImage   = 4'd3;

  typedef struct packed {
    logic [2:0] start_cnt;
    logic       collecting;
    logic [2:0] end_cnt;
    logic [7:0] pbyte;
    logic [2:0] bit_cnt;
    logic       found;
  } dmx_state_t;

  typedef struct packed {
    dmx_state_t st;
    logic       ev_valid;
    logic [1:0] ev_kind;
    logic [7:0] ev_data;
    logic       brk;
  } dmx_step_t;

  // Events produced by one pixel, in order
  typedef struct packed {
    logic [1:0]            ev_count;
    logic [2:0][1:0]       ev_kind;
    logic [2:0][7:0]       ev_data;
  } dmx_bundle_t;

  function automatic logic [3:0] start_digit(input logic kind, input logic [1:0] idx);
    logic [3:0] base;
    base = (kind == MARK_IMAGE) ? StartBaseImage : StartBaseText;
    return base + {3'd0, idx[0]};
  endfunction

  function automatic logic [3:0] end_digit(input logic kind, input logic [1:0] idx);
    logic [3:0] base;
    base = (kind == MARK_IMAGE) ? EndBaseImage : EndBaseText;
    return base + {3'd0, idx[0]};
  endfunction

  // One digit through the hunt / collect state machine
  function automatic dmx_step_t digit_step(input dmx_state_t s, input logic [3:0] d,
                                           input logic kind);
    dmx_step_t  r;
    logic [7:0] shifted;
    r.st       = s;
    r.ev_valid = 1'b0;
    r.ev_kind  = EV_BYTE;
    r.ev_data  = 8'd0;
    r.brk      = 1'b0;
    shifted    = {s.pbyte[6:0], d[0]};
    if (!s.collecting) begin
      if (s.start_cnt < 3'(MarkLen) && d == start_digit(kind, s.start_cnt[1:0])) begin
        r.st.start_cnt = s.start_cnt + 3'd1;
      end else begin
        r.st.start_cnt = (d == start_digit(kind, 2'd0)) ? 3'd1 : 3'd0;
      end
      if (r.st.start_cnt == 3'(MarkLen)) begin
        r.st.collecting = 1'b1;
        r.st.end_cnt    = 3'd0;
      end
    end else if (s.end_cnt < 3'(MarkLen) && d == end_digit(kind, s.end_cnt[1:0])) begin
      r.st.end_cnt = s.end_cnt + 3'd1;
      if (r.st.end_cnt == 3'(MarkLen)) begin
        r.brk = 1'b1;
        if (s.bit_cnt == 3'd0) begin
          r.st.found = 1'b1;
          r.ev_valid = 1'b1;
          r.ev_kind  = EV_FOUND;
        end
      end
    end else if (s.end_cnt != 3'd0 || d > 4'd1) begin
      r.st.collecting = 1'b0;
      r.st.start_cnt  = (d == start_digit(kind, 2'd0)) ? 3'd1 : 3'd0;
      r.st.end_cnt    = 3'd0;
      r.st.pbyte      = 8'd0;
      r.st.bit_cnt    = 3'd0;
      r.ev_valid      = 1'b1;
      r.ev_kind       = EV_DISCARD;
    end else begin
      if (s.bit_cnt == 3'd7) begin
        r.ev_valid   = 1'b1;
        r.ev_kind    = EV_BYTE;
        r.ev_data    = shifted;
        r.st.pbyte   = 8'd0;
        r.st.bit_cnt = 3'd0;
      end else begin
        r.st.pbyte   = shifted;
        r.st.bit_cnt = s.bit_cnt + 3'd1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/decimal_digit_mark_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// First event of a pixel: the lane byte reg loads at the accept edge, then the
// lane digit reg, then the event buffer; a stall holds a stage in between.
// Throughput: one pixel per cycle while pixels yield at most one event each and
// out_ready is high; one event goes out per ready cycle, more events stall input.
// Reset (rst, synchronous): clears the mark state, pipeline and buffer, and
// sets mark_kind and pixel_format to 0.
// ----------------------------------------------------------------------------
// decimal_digit_mark_extractor
// Hunts the last decimal digits of pixel channels for a start mark, packs the
// 0/1 digits after it into bytes and stops at the end mark.
// ----------------------------------------------------------------------------
module decimal_digit_mark_extractor (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data,
  // pixel channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] pixel_word,
  input  wire logic        last_pixel,
  // event channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  event_kind,
  output logic      [7:0]  payload_byte,
  output logic             last_event
);

  // Config registers
  logic mark_kind;
  logic pixel_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_kind    <= 1'b0;
      pixel_format <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dmx_pkg::REG_MARK_KIND:    mark_kind    <= cfg_data;
        dmx_pkg::REG_PIXEL_FORMAT: pixel_format <= cfg_data;
        default:                   ;
      endcase
    end
  end

  // Pipeline control: stage 1 (channel bytes), stage 2 (digits), then the
  // merge step, which fires when its events fit in the output buffer.
  logic s1_valid, s2_valid;
  logic s1_last, s2_last;
  logic s1_ready, s2_ready;
  logic merge_go;
  logic buf_free, pop, pop_last;

  dmx_pkg::dmx_bundle_t bundle;
  logic [3:0][3:0]      digits;

  assign s2_ready = !s2_valid || merge_go;
  assign s1_ready = !s1_valid || s2_ready;
  // no transaction is taken while reset is held
  assign in_ready = s1_ready && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_last <= last_pixel;
    end
    if (s2_ready) begin
      s2_last <= s1_last;
    end
  end

  // Lanes: alpha, red, green, blue in the order the digits are consumed.
  // In RGB565 mode the alpha lane reads as opaque and the color lanes widen
  // their 5- or 6-bit fields.
  dmx_lane u_lane_a (
    .clk       (clk),
    .s1_en     (s1_ready),
    .s2_en     (s2_ready),
    .use565    (pixel_format),
    .fld_kind  (dmx_pkg::FLD_ALPHA),
    .argb_byte (pixel_word[31:24]),
    .rgb_field (6'd0),
    .digit     (digits[0])
  );

  dmx_lane u_lane_r (
    .clk       (clk),
    .s1_en     (s1_ready),
    .s2_en     (s2_ready),
    .use565    (pixel_format),
    .fld_kind  (dmx_pkg::FLD_FIVE),
    .argb_byte (pixel_word[23:16]),
    .rgb_field ({1'b0, pixel_word[15:11]}),
    .digit     (digits[1])
  );

  dmx_lane u_lane_g (
    .clk       (clk),
    .s1_en     (s1_ready),
    .s2_en     (s2_ready),
    .use565    (pixel_format),
    .fld_kind  (dmx_pkg::FLD_SIX),
    .argb_byte (pixel_word[15:8]),
    .rgb_field (pixel_word[10:5]),
    .digit     (digits[2])
  );

  dmx_lane u_lane_b (
    .clk       (clk),
    .s1_en     (s1_ready),
    .s2_en     (s2_ready),
    .use565    (pixel_format),
    .fld_kind  (dmx_pkg::FLD_FIVE),
    .argb_byte (pixel_word[7:0]),
    .rgb_field ({1'b0, pixel_word[4:0]}),
    .digit     (digits[3])
  );

  // Merge: sequential mark logic over the four digits of a pixel
  dmx_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .go        (merge_go),
    .digits    (digits),
    .last      (s2_last),
    .mark_kind (mark_kind),
    .bundle    (bundle)
  );

  // Event buffer: holds one pixel's events and hands them out one per
  // transaction. A pixel with no events passes without touching it.
  logic [2:0][1:0] ob_kind;
  logic [2:0][7:0] ob_data;
  logic [1:0]      ob_count;
  logic [1:0]      ob_idx;
  logic            ob_valid;

  assign pop      = ob_valid && out_ready;
  assign pop_last = pop && (ob_idx == ob_count - 2'd1);
  assign buf_free = !ob_valid || pop_last;
  assign merge_go = s2_valid && (bundle.ev_count == 2'd0 || buf_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      ob_idx   <= 2'd0;
    end else if (merge_go && bundle.ev_count != 2'd0) begin
      ob_valid <= 1'b1;
      ob_idx   <= 2'd0;
    end else if (pop) begin
      if (pop_last) begin
        ob_valid <= 1'b0;
        ob_idx   <= 2'd0;
      end else begin
        ob_idx <= ob_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (merge_go && bundle.ev_count != 2'd0) begin
      ob_kind  <= bundle.ev_kind;
      ob_data  <= bundle.ev_data;
      ob_count <= bundle.ev_count;
    end
  end

  assign out_valid    = ob_valid;
  assign event_kind   = ob_kind[ob_idx];
  assign payload_byte = ob_data[ob_idx];
  assign last_event   = (ob_idx == ob_count - 2'd1);

endmodule
`default_nettype wire

// ===== hdl/dmx_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_lane
// One channel lane: widens the channel to a byte, then takes its last decimal
// digit. Two register stages.
// ----------------------------------------------------------------------------
module dmx_lane (
  input  wire logic       clk,
  input  wire logic       s1_en,
  input  wire logic       s2_en,
  input  wire logic       use565,
  input  wire logic [1:0] fld_kind,
  input  wire logic [7:0] argb_byte,
  input  wire logic [5:0] rgb_field,
  output logic      [3:0] digit
);

  logic [28:0] scaled;
  logic [7:0]  chan_byte;
  logic [7:0]  chan_byte_next;
  logic [15:0] quot_prod;
  logic [4:0]  quot;
  logic [7:0]  rem;

  // stage 1: channel byte
  always_comb begin
    case (fld_kind)
      dmx_pkg::FLD_FIVE: scaled = {24'd0, rgb_field[4:0]} * dmx_pkg::Expand5Mul;
      dmx_pkg::FLD_SIX:  scaled = {23'd0, rgb_field} * dmx_pkg::Expand6Mul;
      default:           scaled = '0;
    endcase
    chan_byte_next = argb_byte;
    if (use565) begin
      if (fld_kind == dmx_pkg::FLD_ALPHA) begin
        chan_byte_next = dmx_pkg::AlphaOpaque;
      end else begin
        chan_byte_next = scaled[dmx_pkg::ExpandShift +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      chan_byte <= chan_byte_next;
    end
  end

  // stage 2: byte mod 10
  always_comb begin
    quot_prod = {8'd0, chan_byte} * dmx_pkg::Div10Mul;
    quot      = quot_prod[dmx_pkg::Div10Shift +: 5];
    rem       = chan_byte - ({quot, 3'b000} + {2'b00, quot, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      digit <= rem[3:0];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dmx_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_merge
// Runs the four lane digits of one pixel through the mark state machine in
// channel order and gathers the resulting events.
// ----------------------------------------------------------------------------
module dmx_merge (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic [3:0][3:0]      digits,
  input  wire logic                 last,
  input  wire logic                 mark_kind,
  output dmx_pkg::dmx_bundle_t      bundle
);

  dmx_pkg::dmx_state_t state;
  dmx_pkg::dmx_state_t state_next;
  dmx_pkg::dmx_step_t  res;
  logic                active;
  logic [1:0]          nev;

  always_comb begin
    state_next = state;
    bundle     = '0;
    nev        = 2'd0;
    active     = !state.found;
    res        = '0;
    for (int i = 0; i < dmx_pkg::NumLanes; i++) begin
      if (active) begin
        res        = dmx_pkg::digit_step(state_next, digits[i], mark_kind);
        state_next = res.st;
        if (res.ev_valid && nev < 2'(dmx_pkg::MaxEvents)) begin
          bundle.ev_kind[nev] = res.ev_kind;
          bundle.ev_data[nev] = res.ev_data;
          nev                 = nev + 2'd1;
        end
        if (res.brk) begin
          active = 1'b0;
        end
      end
    end
    // end of image without a mark (not raised for a pixel seen after a find)
    if (last && !state_next.found && nev < 2'(dmx_pkg::MaxEvents)) begin
      bundle.ev_kind[nev] = dmx_pkg::EV_NOT_FOUND;
      bundle.ev_data[nev] = 8'd0;
      nev                 = nev + 2'd1;
    end
    bundle.ev_count = nev;
    if (last) begin
      state_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (go) begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
